FILE: rtl/rhh_pkg.sv
package rhh_pkg;

    localparam int SLOTS = 256;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_SMALL = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [1:0] FLAG_EMPTY = 2'd0;
    localparam logic [1:0] FLAG_OCC   = 2'd1;
    localparam logic [1:0] FLAG_DEL   = 2'd2;

    localparam logic [31:0] MIX_C1 = 32'h7feb352d;
    localparam logic [31:0] MIX_C2 = 32'h846ca68b;
    localparam logic [8:0]  MAX_ENTRIES_RESET = 9'd179;

    typedef enum logic [2:0] {
        MX_IDLE = 3'b001,
        MX_MUL1 = 3'b010,
        MX_MUL2 = 3'b100
    } t_mix_state;

endpackage

FILE: rtl/robin_hood_hash_table_top.sv
// Channel   Direction  Handshake             Payload
// command   in         start / busy          i_opcode i_key i_value i_length
// result    out        o_done (one cycle)    o_status o_value_out o_length_out o_entry_count
// config    in         i_cfg_we              i_cfg_wdata (max_entries)
// After the synchronous reset a clearing pass marks every slot empty, with busy
// high. A command with a valid opcode hashes its key, then probes slots (memory
// read, compare, advance); other opcodes go straight to done. On each occupied
// slot an insert also hashes the resident and compares distances. An insert
// first walks without writing, then passes through S_WAIT and S_WRITE and walks
// again to commit. o_done is registered from S_DONE, and busy is already low in
// the cycle that o_done is high. Results cannot be stalled.
module robin_hood_hash_table_top #(
    parameter int VALUE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic signed [31:0] i_key,
    input  logic [63:0] i_value,
    input  logic [3:0]  i_length,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [63:0] o_value_out,
    output logic [3:0]  o_length_out,
    output logic [8:0]  o_entry_count
);
    import rhh_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = AW + 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_HASH  = 11'b00000000010,
        S_READ  = 11'b00000000100,
        S_EXAM  = 11'b00000001000,
        S_RHASH = 11'b00000010000,
        S_RCMP  = 11'b00000100000,
        S_ADV   = 11'b00001000000,
        S_WRITE = 11'b00010000000,
        S_DONE  = 11'b00100000000,
        S_WAIT  = 11'b01000000000,
        S_CLR   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]  r_flag [SLOTS];
    logic [31:0] m_key [SLOTS];
    logic [VALUE_BITS-1:0] m_val [SLOTS];
    logic [3:0]  m_len [SLOTS];
    logic [31:0] r_rk;
    logic [VALUE_BITS-1:0] r_rv;
    logic [3:0]  r_rl;
    logic [1:0]  r_rf;

    logic [1:0]  r_op;
    logic        r_commit;
    logic [31:0] r_k, r_ck;
    logic [VALUE_BITS-1:0] r_cv, r_v0;
    logic [3:0]  r_cl, r_len;
    logic [AW-1:0] r_home, r_idx;
    logic [CW-1:0] r_dist, r_step;
    logic [8:0]  r_count, r_max;

    logic        r_done;
    logic [1:0]  r_status;
    logic [63:0] r_vout;
    logic [3:0]  r_lout;

    logic        w_mstart, w_mdone;
    logic [31:0] w_mkey, w_hash;
    logic [AW-1:0] w_rhome, w_rd_lo;
    logic        w_we_kv, w_we_flag;
    logic [1:0]  w_flag_d;
    logic [CW-1:0] w_rd;

    rhh_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_key   (w_mkey),
        .o_done  (w_mdone),
        .o_hash  (w_hash)
    );

    // The command key is hashed straight from the port in the accepting cycle.
    assign w_mkey   = (r_state == S_IDLE) ? i_key : r_rk;
    assign w_rhome  = w_hash[AW-1:0];
    assign w_rd_lo  = r_idx - w_rhome;
    assign w_rd     = {1'b0, w_rd_lo};
    assign busy     = (r_state != S_IDLE);

    always_comb begin
        w_mstart  = 1'b0;
        w_we_kv   = 1'b0;
        w_we_flag = 1'b0;
        w_flag_d  = FLAG_OCC;
        n_state   = r_state;
        case (r_state)
            S_IDLE: if (start) begin
                if (i_opcode inside {OP_INSERT, OP_LOOKUP, OP_REMOVE}) begin
                    w_mstart = 1'b1;
                    n_state  = S_HASH;
                end else n_state = S_DONE;
            end
            S_CLR: begin
                w_we_flag = 1'b1;
                w_flag_d  = FLAG_EMPTY;
                if (r_idx == AW'(SLOTS - 1)) n_state = S_IDLE;
            end
            S_HASH:  if (w_mdone) n_state = S_READ;
            S_READ:  n_state = S_EXAM;
            S_EXAM: begin
                if (r_op == OP_INSERT) begin
                    if (r_rf != FLAG_OCC) begin
                        if (!r_commit && r_count >= r_max) n_state = S_DONE;
                        else if (!r_commit) n_state = S_WAIT;
                        else begin
                            w_we_kv = 1'b1;
                            w_we_flag = 1'b1;
                            n_state = S_DONE;
                        end
                    end else begin
                        w_mstart = 1'b1;
                        n_state  = S_RHASH;
                    end
                end else begin
                    if (r_rf == FLAG_EMPTY) n_state = S_DONE;
                    else if (r_rf == FLAG_OCC && r_rk == r_k) begin
                        if (r_op == OP_REMOVE) begin
                            w_we_flag = 1'b1;
                            w_flag_d  = FLAG_DEL;
                        end
                        n_state = S_DONE;
                    end else n_state = S_ADV;
                end
            end
            S_RHASH: if (w_mdone) n_state = S_RCMP;
            S_RCMP: begin
                if (w_rd < r_dist) begin
                    w_we_kv = r_commit;
                    n_state = S_ADV;
                end else if (r_rk == r_ck) begin
                    w_we_kv = r_commit;
                    n_state = r_commit ? S_DONE : S_WAIT;
                end else n_state = S_ADV;
            end
            S_ADV:   n_state = (r_step == CW'(SLOTS - 1)) ? S_DONE : S_READ;
            S_WAIT:  n_state = S_WRITE;
            S_WRITE: n_state = S_READ;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we_kv) begin
            m_key[r_idx] <= r_ck;
            m_val[r_idx] <= r_cv;
            m_len[r_idx] <= r_cl;
        end
        r_rk <= m_key[r_idx];
        r_rv <= m_val[r_idx];
        r_rl <= m_len[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
            r_count <= '0;
            r_max   <= MAX_ENTRIES_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_DONE);
            if (i_cfg_we) r_max <= i_cfg_wdata;
            if (w_we_flag) r_flag[r_idx] <= w_flag_d;
            r_rf <= r_flag[r_idx];
            case (r_state)
                S_CLR: r_idx <= r_idx + AW'(1);
                S_IDLE: if (start) begin
                    r_op <= i_opcode; r_k <= i_key; r_ck <= i_key;
                    r_cv <= i_value[VALUE_BITS-1:0]; r_cl <= i_length;
                    r_v0 <= i_value[VALUE_BITS-1:0];
                    r_len <= i_length; r_commit <= 1'b0;
                    r_dist <= '0; r_step <= '0;
                    r_status <= ST_OK; r_vout <= '0; r_lout <= '0;
                end
                S_HASH: if (w_mdone) begin
                    r_home <= w_hash[AW-1:0];
                    r_idx  <= w_hash[AW-1:0];
                end
                S_EXAM: begin
                    if (r_op == OP_INSERT) begin
                        if (r_rf != FLAG_OCC) begin
                            if (!r_commit && r_count >= r_max) r_status <= ST_FULL;
                            if (r_commit) r_count <= r_count + 9'd1;
                        end
                    end else if (r_rf == FLAG_EMPTY) r_status <= ST_MISS;
                    else if (r_rf == FLAG_OCC && r_rk == r_k) begin
                        if (r_op == OP_REMOVE) r_count <= r_count - 9'd1;
                        else if (r_len < r_rl) r_status <= ST_SMALL;
                        else begin
                            r_vout <= 64'(r_rv);
                            r_lout <= r_rl;
                        end
                    end
                end
                S_RCMP: if (w_rd < r_dist) begin
                    r_ck <= r_rk; r_cv <= r_rv; r_cl <= r_rl;
                    r_dist <= w_rd;
                end
                S_ADV: begin
                    r_idx  <= (r_idx == AW'(SLOTS - 1)) ? '0 : r_idx + AW'(1);
                    r_dist <= r_dist + CW'(1);
                    r_step <= r_step + CW'(1);
                    if (r_step == CW'(SLOTS - 1)) begin
                        r_status <= (r_op == OP_INSERT) ? ST_FULL : ST_MISS;
                    end
                end
                S_WAIT: begin
                    // Dry run succeeded; restart the walk with writes enabled.
                    r_commit <= 1'b1;
                    r_idx <= r_home; r_dist <= '0; r_step <= '0;
                    r_ck <= r_k; r_cv <= r_v0; r_cl <= r_len;
                end
                S_WRITE: r_cv <= r_cv;
                default: ;
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_value_out   = r_vout;
    assign o_length_out  = r_lout;
    assign o_entry_count = r_count;
endmodule

FILE: rtl/rhh_mix.sv
module rhh_mix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_key,
    output logic        o_done,
    output logic [31:0] o_hash
);
    import rhh_pkg::*;

    t_mix_state  r_state, n_state;
    logic [31:0] r_x, n_x;
    logic        r_done, n_done;
    logic [31:0] w_a, w_c, w_p;

    // One 32-bit multiplier shared by both rounds of the mix.
    always_comb begin
        if (r_state == MX_MUL1) begin
            w_a = r_x ^ (r_x >> 16);
            w_c = MIX_C1;
        end else begin
            w_a = r_x ^ (r_x >> 15);
            w_c = MIX_C2;
        end
        w_p = w_a * w_c;
    end

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_done  = 1'b0;
        case (r_state)
            MX_IDLE: begin
                if (i_start) begin
                    n_x     = i_key;
                    n_state = MX_MUL1;
                end
            end
            MX_MUL1: begin
                n_x     = w_p;
                n_state = MX_MUL2;
            end
            MX_MUL2: begin
                n_x     = w_p ^ (w_p >> 16);
                n_done  = 1'b1;
                n_state = MX_IDLE;
            end
            default: n_state = MX_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MX_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_x <= n_x;
    end

    assign o_done = r_done;
    assign o_hash = r_x;
endmodule

FILE: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rhh_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int NSLOT = 256;
    localparam int STALL_LIMIT = 40000;

    typedef enum logic [1:0] {K_CMD, K_CFG, K_DRAIN, K_IDLE} t_kind;

    typedef struct {
        t_kind       kind;
        logic [1:0]  op;
        logic [31:0] key;
        logic [63:0] val;
        logic [3:0]  len;
        logic [8:0]  data;
    } t_item;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] val;
        logic [3:0]  len;
        logic [8:0]  count;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = '0;
    logic signed [31:0] i_key = '0;
    logic [63:0] i_value = '0;
    logic [3:0]  i_length = '0;
    logic        i_cfg_we = 1'b0;
    logic [8:0]  i_cfg_wdata = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [63:0] o_value_out;
    logic [3:0]  o_length_out;
    logic [8:0]  o_entry_count;

    robin_hood_hash_table_top dut (.*);

    always #10 i_clk = ~i_clk;

    t_item   pending_q[$];
    t_result result_q[$];
    int      errors = 0;
    int      idle_pct = 0;
    int      drain_wait = 0;
    int      quiet_cycles = 0;
    logic    took = 1'b0;
    logic [31:0] key_pool[320];

    // Shadow copy of the table.
    logic [1:0]  tbl_flag[NSLOT];
    logic [31:0] tbl_key[NSLOT];
    logic [63:0] tbl_val[NSLOT];
    logic [3:0]  tbl_len[NSLOT];
    logic [8:0]  tbl_count = '0;
    logic [8:0]  tbl_limit = MAX_ENTRIES_RESET;

    function automatic logic [7:0] home_slot(logic [31:0] k);
        logic [31:0] x;
        x = k ^ (k >> 16);
        x = x * MIX_C1;
        x = x ^ (x >> 15);
        x = x * MIX_C2;
        x = x ^ (x >> 16);
        return x[7:0];
    endfunction

    // Returns 0 when no end is found in a full pass, 1 on a new slot, 2 on an update.
    function automatic int insert_walk(logic [31:0] k, logic [63:0] v, logic [3:0] l,
                                       bit commit);
        logic [31:0] ck, rk;
        logic [63:0] cv, rv;
        logic [3:0]  cl, rl;
        logic [7:0]  idx, rdist;
        int          walk_dist;
        ck = k; cv = v; cl = l; idx = home_slot(k); walk_dist = 0;
        for (int s = 0; s < NSLOT; s++) begin
            if (tbl_flag[idx] != FLAG_OCC) begin
                if (commit) begin
                    tbl_flag[idx] = FLAG_OCC;
                    tbl_key[idx] = ck;
                    tbl_val[idx] = cv;
                    tbl_len[idx] = cl;
                    tbl_count++;
                end
                return 1;
            end
            rk = tbl_key[idx];
            rdist = idx - home_slot(rk);
            if (int'(rdist) < walk_dist) begin
                rv = tbl_val[idx];
                rl = tbl_len[idx];
                if (commit) begin
                    tbl_key[idx] = ck;
                    tbl_val[idx] = cv;
                    tbl_len[idx] = cl;
                end
                ck = rk; cv = rv; cl = rl;
                walk_dist = int'(rdist);
            end else if (rk == ck) begin
                if (commit) begin
                    tbl_val[idx] = cv;
                    tbl_len[idx] = cl;
                end
                return 2;
            end
            idx++;
            walk_dist++;
        end
        return 0;
    endfunction

    function automatic int find_slot(logic [31:0] k);
        logic [7:0] idx;
        idx = home_slot(k);
        for (int s = 0; s < NSLOT; s++) begin
            if (tbl_flag[idx] == FLAG_EMPTY) return -1;
            if (tbl_flag[idx] == FLAG_OCC && tbl_key[idx] == k) return int'(idx);
            idx++;
        end
        return -1;
    endfunction

    function automatic t_result predict_result(logic [1:0] op, logic [31:0] k,
                                               logic [63:0] v, logic [3:0] l);
        t_result r;
        int      walk, pos;
        r = '{status: ST_OK, val: '0, len: '0, count: '0};
        case (op)
            OP_INSERT: begin
                walk = insert_walk(k, v, l, 1'b0);
                if (walk == 0 || (walk == 1 && tbl_count >= tbl_limit))
                    r.status = ST_FULL;
                else
                    void'(insert_walk(k, v, l, 1'b1));
            end
            OP_LOOKUP: begin
                pos = find_slot(k);
                if (pos < 0) r.status = ST_MISS;
                else if (l < tbl_len[pos]) r.status = ST_SMALL;
                else begin
                    r.val = tbl_val[pos];
                    r.len = tbl_len[pos];
                end
            end
            OP_REMOVE: begin
                pos = find_slot(k);
                if (pos < 0) r.status = ST_MISS;
                else begin
                    tbl_flag[pos] = FLAG_DEL;
                    tbl_count--;
                end
            end
            default: ;
        endcase
        r.count = tbl_count;
        return r;
    endfunction

    task automatic push_cmd(logic [1:0] op, logic [31:0] k, logic [63:0] v, logic [3:0] l);
        pending_q.push_back('{kind: K_CMD, op: op, key: k, val: v, len: l, data: '0});
    endtask

    task automatic push_ctl(t_kind kind, logic [8:0] data);
        pending_q.push_back('{kind: kind, op: '0, key: '0, val: '0, len: '0, data: data});
    endtask

    task automatic push_random_ops(int count, int pool_n);
        int          pick;
        logic [1:0]  op;
        logic [31:0] k;
        logic [3:0]  l;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) op = OP_INSERT;
            else if (pick < 78) op = OP_LOOKUP;
            else if (pick < 98) op = OP_REMOVE;
            else op = OP_NOP;
            k = ($urandom_range(0, 99) < 4) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
            if (op == OP_INSERT && $urandom_range(0, 99) >= 15) l = 4'($urandom_range(0, 8));
            else l = 4'($urandom_range(0, 15));
            push_cmd(op, k, {$urandom, $urandom}, l);
        end
    endtask

    // Sender: one decision per falling edge, one assignment per signal.
    always @(negedge i_clk) begin
        logic next_start, next_we;
        next_start = start;
        next_we = 1'b0;
        if (i_rst_n && !(start && !took)) begin
            next_start = 1'b0;
            if (pending_q.size() > 0) begin
                case (pending_q[0].kind)
                    K_IDLE: begin
                        idle_pct = int'(pending_q[0].data);
                        void'(pending_q.pop_front());
                    end
                    K_DRAIN, K_CFG: begin
                        if (result_q.size() == 0 && !busy && !start) drain_wait++;
                        else drain_wait = 0;
                        if (drain_wait >= 8) begin
                            drain_wait = 0;
                            if (pending_q[0].kind == K_CFG) begin
                                next_we = 1'b1;
                                i_cfg_wdata <= pending_q[0].data;
                            end
                            void'(pending_q.pop_front());
                        end
                    end
                    default: begin
                        if ($urandom_range(0, 99) >= idle_pct) begin
                            i_opcode <= pending_q[0].op;
                            i_key <= pending_q[0].key;
                            i_value <= pending_q[0].val;
                            i_length <= pending_q[0].len;
                            next_start = 1'b1;
                            void'(pending_q.pop_front());
                        end
                    end
                endcase
            end
        end
        start <= next_start;
        i_cfg_we <= next_we;
    end

    // Monitor: results are checked before the command taken at the same edge is predicted.
    always @(posedge i_clk) begin
        t_result got, want;
        took <= start && !busy;
        if (i_rst_n) begin
            quiet_cycles++;
            if (o_done) begin
                quiet_cycles = 0;
                got = '{status: o_status, val: o_value_out, len: o_length_out,
                        count: o_entry_count};
                if (result_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected: status %0d count %0d",
                             $time, got.status, got.count);
                end else begin
                    want = result_q.pop_front();
                    if (got.status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.val !== want.val) begin
                        errors++;
                        $display("%0t: value_out expected %h actual %h",
                                 $time, want.val, got.val);
                    end
                    if (got.len !== want.len) begin
                        errors++;
                        $display("%0t: length_out expected %0d actual %0d",
                                 $time, want.len, got.len);
                    end
                    if (got.count !== want.count) begin
                        errors++;
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.count, got.count);
                    end
                end
            end
            if (start && !busy) begin
                quiet_cycles = 0;
                result_q.push_back(predict_result(i_opcode, i_key, i_value, i_length));
            end
            if (i_cfg_we) tbl_limit = i_cfg_wdata;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] base;
        base = $urandom;
        for (int n = 0; n < 320; n++) key_pool[n] = base ^ (n * 32'h9e3779b1);
        for (int n = 0; n < NSLOT; n++) tbl_flag[n] = FLAG_EMPTY;

        // Directed: extremes, every operation, each corner case.
        push_cmd(OP_LOOKUP, 32'h0, '0, 4'd8);
        push_cmd(OP_REMOVE, 32'h0, '0, 4'd0);
        push_cmd(OP_INSERT, 32'h8000_0000, '1, 4'd8);
        push_cmd(OP_INSERT, 32'h7fff_ffff, 64'h0, 4'd0);
        push_cmd(OP_INSERT, 32'hffff_ffff, 64'h0123_4567_89ab_cdef, 4'd15);
        push_cmd(OP_INSERT, 32'h0, 64'haaaa_5555_aaaa_5555, 4'd5);
        push_cmd(OP_LOOKUP, 32'h8000_0000, '0, 4'd8);
        push_cmd(OP_LOOKUP, 32'h8000_0000, '0, 4'd7);
        push_cmd(OP_LOOKUP, 32'hffff_ffff, '0, 4'd15);
        push_cmd(OP_LOOKUP, 32'h7fff_ffff, '0, 4'd0);
        push_cmd(OP_INSERT, 32'h0, 64'h5555_aaaa_5555_aaaa, 4'd3);
        push_cmd(OP_LOOKUP, 32'h0, '1, 4'd3);
        push_cmd(OP_REMOVE, 32'h7fff_ffff, '0, 4'd0);
        push_cmd(OP_LOOKUP, 32'h7fff_ffff, '0, 4'd8);
        push_cmd(OP_REMOVE, 32'h7fff_ffff, '0, 4'd0);
        push_cmd(OP_NOP, 32'hffff_ffff, '1, 4'd15);
        push_ctl(K_CFG, 9'd4);
        push_cmd(OP_INSERT, key_pool[0], '1, 4'd2);
        push_cmd(OP_INSERT, key_pool[1], '1, 4'd2);
        push_cmd(OP_INSERT, 32'h0, 64'h1, 4'd1);
        push_cmd(OP_LOOKUP, 32'h0, '0, 4'd1);
        push_ctl(K_CFG, 9'd0);
        push_cmd(OP_INSERT, key_pool[2], '1, 4'd8);
        push_cmd(OP_INSERT, 32'h8000_0000, 64'h2, 4'd2);

        // Fill every slot, then push past a full pass, then empty it into tombstones.
        push_ctl(K_CFG, 9'd511);
        for (int n = 0; n < 258; n++)
            push_cmd(OP_INSERT, key_pool[n], {$urandom, $urandom}, 4'($urandom_range(0, 8)));
        push_cmd(OP_LOOKUP, key_pool[300], '0, 4'd8);
        push_cmd(OP_LOOKUP, key_pool[100], '0, 4'd8);
        push_ctl(K_IDLE, 9'd59);
        for (int n = 0; n < 258; n += 2) push_cmd(OP_REMOVE, key_pool[n], '0, 4'd0);
        push_cmd(OP_INSERT, key_pool[1], 64'h3, 4'd3);
        push_ctl(K_DRAIN, 9'd0);
        push_ctl(K_CFG, 9'd256);
        for (int n = 1; n < 258; n += 2) push_cmd(OP_REMOVE, key_pool[n], '0, 4'd0);

        push_ctl(K_IDLE, 9'd0);
        push_ctl(K_CFG, MAX_ENTRIES_RESET);
        push_random_ops(60, 40);
        push_ctl(K_IDLE, 9'd59);
        push_random_ops(60, 320);
        push_ctl(K_CFG, 9'd1);
        push_ctl(K_IDLE, 9'd27);
        push_random_ops(40, 12);
        push_ctl(K_CFG, 9'($urandom_range(2, 300)));
        push_random_ops(50, 200);
        push_ctl(K_IDLE, 9'd0);
        push_ctl(K_CFG, 9'd256);
        push_random_ops(50, 320);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !start && result_q.size() == 0);
        repeat (3000) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (result_q.size() != 0)
                $display("%0t: %0d results never arrived", $time, result_q.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rhh_pkg.sv
rtl/rhh_mix.sv
rtl/robin_hood_hash_table_top.sv
dv/tb.sv
